>>> rtl/prlm_pkg.sv
// prlm_pkg: shared types and constants of the pulse rate level meter with beeper
// register indexes, reset values, configuration and result bundles
// no dependencies
`default_nettype none

package prlm_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 48;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_MS      = 3'd0,
        CFG_DEBOUNCE_MS    = 3'd1,
        CFG_UP_THRESHOLDS  = 3'd2,
        CFG_DOWN_MARGIN    = 3'd3,
        CFG_BEEP_ON_MS     = 3'd4,
        CFG_BEEP_OFF_TIMES = 3'd5
    } cfg_idx_t;

    localparam logic [15:0] WINDOW_MS_RST      = 16'd200;
    localparam logic [7:0]  DEBOUNCE_MS_RST    = 8'd50;
    localparam logic [31:0] UP_THRESHOLDS_RST  = 32'h281E_140A;
    localparam logic [7:0]  DOWN_MARGIN_RST    = 8'd3;
    localparam logic [7:0]  BEEP_ON_MS_RST     = 8'd30;
    localparam logic [47:0] BEEP_OFF_TIMES_RST = 48'h01E_050_0B4_190;

    localparam logic [2:0] LEVEL_MAX = 3'd5;

    typedef struct packed {
        logic [15:0] window_ms;
        logic [7:0]  debounce_ms;
        logic [31:0] up_thresholds;
        logic [7:0]  down_margin;
        logic [7:0]  beep_on_ms;
        logic [47:0] beep_off_times;
    } cfg_t;

    typedef struct packed {
        logic [2:0] field_level;
        logic [4:0] led_bar;
        logic       buzzer_drive;
        logic       beep_enabled;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/prlm_cfg_regs.sv
// prlm_cfg_regs: configuration register file, written by index
// depends on prlm_pkg
`default_nettype none

module prlm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [prlm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [prlm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output prlm_pkg::cfg_t                        cfg
);

    prlm_pkg::cfg_t cfg_reg;
    prlm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                prlm_pkg::CFG_WINDOW_MS:      cfg_next.window_ms      = cfg_data[15:0];
                prlm_pkg::CFG_DEBOUNCE_MS:    cfg_next.debounce_ms    = cfg_data[7:0];
                prlm_pkg::CFG_UP_THRESHOLDS:  cfg_next.up_thresholds  = cfg_data[31:0];
                prlm_pkg::CFG_DOWN_MARGIN:    cfg_next.down_margin    = cfg_data[7:0];
                prlm_pkg::CFG_BEEP_ON_MS:     cfg_next.beep_on_ms     = cfg_data[7:0];
                prlm_pkg::CFG_BEEP_OFF_TIMES: cfg_next.beep_off_times = cfg_data[47:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms      <= prlm_pkg::WINDOW_MS_RST;
            cfg_reg.debounce_ms    <= prlm_pkg::DEBOUNCE_MS_RST;
            cfg_reg.up_thresholds  <= prlm_pkg::UP_THRESHOLDS_RST;
            cfg_reg.down_margin    <= prlm_pkg::DOWN_MARGIN_RST;
            cfg_reg.beep_on_ms     <= prlm_pkg::BEEP_ON_MS_RST;
            cfg_reg.beep_off_times <= prlm_pkg::BEEP_OFF_TIMES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/prlm_core.sv
// prlm_core: meter state and its one-sample update (debounce, window, beeper)
// depends on prlm_pkg
`default_nettype none

module prlm_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire prlm_pkg::cfg_t cfg,
    input  wire logic           antenna_level,
    input  wire logic           button_level,
    input  wire logic           ms_tick,
    output prlm_pkg::result_t   result
);

    logic [2:0]  level_reg,            level_next;
    logic [15:0] edge_count_reg,       edge_count_next;
    logic        antenna_prev_reg,     antenna_prev_next;
    logic [15:0] window_elapsed_reg,   window_elapsed_next;
    logic        button_raw_prev_reg,  button_raw_prev_next;
    logic        button_stable_reg,    button_stable_next;
    logic [7:0]  debounce_elapsed_reg, debounce_elapsed_next;
    logic        enable_reg,           enable_next;
    logic        phase_on_reg,         phase_on_next;
    logic [11:0] beep_elapsed_reg,     beep_elapsed_next;

    logic [15:0] win_e;
    logic [7:0]  deb_e;
    logic [11:0] beep_e;
    logic        accept_btn;
    logic [15:0] cnt1;
    logic [7:0]  up_next_thr;
    logic [7:0]  up_cur_thr;
    logic [7:0]  down_thr;
    logic        down_ok;
    logic [11:0] limit;
    logic        beep_active;
    logic        drive;

    // count needed to reach level lv, zero outside levels 2..5
    function automatic logic [7:0] up_of(input logic [2:0] lv, input logic [31:0] thr);
        logic [7:0] r;
        case (lv)
            3'd2:    r = thr[7:0];
            3'd3:    r = thr[15:8];
            3'd4:    r = thr[23:16];
            3'd5:    r = thr[31:24];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // silent time for level lv, levels outside 3..5 use the level 2 field
    function automatic logic [11:0] off_of(input logic [2:0] lv, input logic [47:0] offs);
        logic [11:0] r;
        case (lv)
            3'd3:    r = offs[23:12];
            3'd4:    r = offs[35:24];
            3'd5:    r = offs[47:36];
            default: r = offs[11:0];
        endcase
        return r;
    endfunction

    always_comb
    begin
        // saturating elapsed counters
        win_e  = (ms_tick && window_elapsed_reg != 16'hFFFF)
                 ? window_elapsed_reg + 16'd1 : window_elapsed_reg;
        deb_e  = (ms_tick && debounce_elapsed_reg != 8'hFF)
                 ? debounce_elapsed_reg + 8'd1 : debounce_elapsed_reg;
        beep_e = (ms_tick && beep_elapsed_reg != 12'hFFF)
                 ? beep_elapsed_reg + 12'd1 : beep_elapsed_reg;

        // button debounce
        if (button_level != button_raw_prev_reg)
            deb_e = 8'd0;
        accept_btn           = (deb_e >= cfg.debounce_ms) && (button_level != button_stable_reg);
        button_stable_next   = accept_btn ? button_level : button_stable_reg;
        enable_next          = enable_reg ^ (accept_btn && !button_level);
        button_raw_prev_next = button_level;
        debounce_elapsed_next = deb_e;

        // antenna edges and counting window
        cnt1 = (antenna_level && !antenna_prev_reg && edge_count_reg != 16'hFFFF)
               ? edge_count_reg + 16'd1 : edge_count_reg;
        up_next_thr = up_of(level_reg + 3'd1, cfg.up_thresholds);
        up_cur_thr  = up_of(level_reg, cfg.up_thresholds);
        down_ok     = up_cur_thr >= cfg.down_margin;
        down_thr    = up_cur_thr - cfg.down_margin;
        level_next          = level_reg;
        edge_count_next     = cnt1;
        window_elapsed_next = win_e;
        if (win_e >= cfg.window_ms)
        begin
            if (level_reg < prlm_pkg::LEVEL_MAX && cnt1 >= {8'd0, up_next_thr})
                level_next = level_reg + 3'd1;
            else if (level_reg > 3'd1 && down_ok && cnt1 <= {8'd0, down_thr})
                level_next = level_reg - 3'd1;
            edge_count_next     = 16'd0;
            window_elapsed_next = 16'd0;
        end
        antenna_prev_next = antenna_level;

        // beeper, on the updated level and enable
        beep_active       = enable_next && (level_next > 3'd1);
        limit             = phase_on_reg ? {4'd0, cfg.beep_on_ms}
                                         : off_of(level_next, cfg.beep_off_times);
        phase_on_next     = phase_on_reg;
        beep_elapsed_next = beep_e;
        drive             = 1'b1;
        if (beep_active)
        begin
            if (beep_e >= limit)
            begin
                phase_on_next     = !phase_on_reg;
                beep_elapsed_next = 12'd0;
            end
            drive = !phase_on_next;
        end

        result.field_level  = level_next;
        result.led_bar      = 5'((6'd1 << level_next) - 6'd1);
        result.buzzer_drive = drive;
        result.beep_enabled = enable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg            <= 3'd0;
            edge_count_reg       <= 16'd0;
            antenna_prev_reg     <= 1'b0;
            window_elapsed_reg   <= 16'd0;
            button_raw_prev_reg  <= 1'b1;
            button_stable_reg    <= 1'b1;
            debounce_elapsed_reg <= 8'd0;
            enable_reg           <= 1'b0;
            phase_on_reg         <= 1'b0;
            beep_elapsed_reg     <= 12'd0;
        end
        else if (advance)
        begin
            level_reg            <= level_next;
            edge_count_reg       <= edge_count_next;
            antenna_prev_reg     <= antenna_prev_next;
            window_elapsed_reg   <= window_elapsed_next;
            button_raw_prev_reg  <= button_raw_prev_next;
            button_stable_reg    <= button_stable_next;
            debounce_elapsed_reg <= debounce_elapsed_next;
            enable_reg           <= enable_next;
            phase_on_reg         <= phase_on_next;
            beep_elapsed_reg     <= beep_elapsed_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pulse_rate_level_meter_beeper.sv
// pulse_rate_level_meter_beeper: top level, input register, result register
// depends on prlm_pkg, prlm_cfg_regs, prlm_core
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  antenna_level, button_level, ms_tick
//   out      source     out_valid/ out_stall field_level, led_bar, buzzer_drive, beep_enabled
//   cfg      sink       cfg_we               cfg_index, cfg_data (no read-back)
//
// one sample per clock sustained while out_stall is low; input register then result register
// the meter state updates as a sample moves from the input register to the result register
// a stalled result holds and the input register keeps taking samples until it is full too
// rst_n asynchronously clears control state and loads register defaults
`default_nettype none

module pulse_rate_level_meter_beeper (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // sample channel
    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire logic                             antenna_level,
    input  wire logic                             button_level,
    input  wire logic                             ms_tick,
    // result channel
    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      logic [2:0]                       field_level,
    output      logic [4:0]                       led_bar,
    output      logic                             buzzer_drive,
    output      logic                             beep_enabled,
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [prlm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [prlm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    prlm_pkg::cfg_t    cfg;
    prlm_pkg::result_t core_result;

    // input register
    logic s1_valid_reg, s1_valid_next;
    logic s1_antenna_reg, s1_button_reg, s1_tick_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    prlm_pkg::result_t out_reg;

    logic out_ready;
    logic s1_fire;
    logic in_fire;

    // result register can load when empty or being drained this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_fire   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_antenna_reg <= antenna_level;
            s1_button_reg  <= button_level;
            s1_tick_reg    <= ms_tick;
        end
        if (s1_fire)
            out_reg <= core_result;
    end

    prlm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state advances once per transaction leaving the input register
    prlm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (s1_fire),
        .cfg           (cfg),
        .antenna_level (s1_antenna_reg),
        .button_level  (s1_button_reg),
        .ms_tick       (s1_tick_reg),
        .result        (core_result)
    );

    assign out_valid    = out_valid_reg;
    assign field_level  = out_reg.field_level;
    assign led_bar      = out_reg.led_bar;
    assign buzzer_drive = out_reg.buzzer_drive;
    assign beep_enabled = out_reg.beep_enabled;

`ifndef SYNTH
    // an accepted sample always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted sample lost");

    // a full input register never sees a result register that could take it idle
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_ready) |=> out_valid_reg)
        else $error("result register did not load");

    // buzzer sounds only with the beeper enabled and level two or more
    a_buzzer_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.buzzer_drive) |->
            (out_reg.beep_enabled && out_reg.field_level > 3'd1))
        else $error("buzzer sounding while silent");

    // level stays in range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.field_level <= prlm_pkg::LEVEL_MAX)
        else $error("level out of range");
`endif

endmodule

`default_nettype wire
